>>> rtl/core/lav_pkg.sv
// Look-at view matrix: shared types and fixed-point constants.
// No dependencies; compiled first.
`default_nettype none

package lav_pkg;

	// Fraction bits of the rotation entries (Q2.14)
	localparam int ROT_FRAC = 14;

	// One request: eye, target and up hint, signed fixed point
	typedef struct packed {
		logic signed [31:0] eye_px;
		logic signed [31:0] eye_py;
		logic signed [31:0] eye_pz;
		logic signed [31:0] target_px;
		logic signed [31:0] target_py;
		logic signed [31:0] target_pz;
		logic signed [31:0] up_hint_x;
		logic signed [31:0] up_hint_y;
		logic signed [31:0] up_hint_z;
	} cmd_t;

	// One result: rotation rows in Q2.14, translation in input format
	typedef struct packed {
		logic signed [15:0] side_ax;
		logic signed [15:0] side_ay;
		logic signed [15:0] side_az;
		logic signed [15:0] true_up_x;
		logic signed [15:0] true_up_y;
		logic signed [15:0] true_up_z;
		logic signed [15:0] fwd_ax;
		logic signed [15:0] fwd_ay;
		logic signed [15:0] fwd_az;
		logic signed [31:0] shift_x;
		logic signed [31:0] shift_y;
		logic signed [31:0] shift_z;
	} rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/lav_cmd_if.sv
// Request channel of the look-at block: valid/ready plus cmd_t payload.
// Depends on lav_pkg.
`default_nettype none

interface lav_cmd_if;
	logic          valid;
	logic          ready;
	lav_pkg::cmd_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lav_rsp_if.sv
// Result channel of the look-at block: valid/ready plus rsp_t payload.
// Depends on lav_pkg.
`default_nettype none

interface lav_rsp_if;
	logic          valid;
	logic          ready;
	lav_pkg::rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lav_norm3.sv
// Pipelined 3-vector normalizer to Q2.14: scale, sum of squares, square root,
// per-lane restoring divide. Carries a side payload along. Depends on lav_pkg.
`default_nettype none

module lav_norm3 #(
	parameter int W  = 33,
	parameter int SW = 96
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire                  vld_in,
	input  wire [2:0][W-1:0]     v_in,
	input  wire [SW-1:0]         side_in,
	output logic                 vld_out,
	output logic [2:0][15:0]     q_out,
	output logic [SW-1:0]        side_out
);

	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = lav_pkg::ROT_FRAC + 1;
	localparam int LAT       = 1 + 3 + 1 + 1 + SQ_STEPS + 1 + DIV_STEPS + 1;
	localparam int TW        = SW + 4;
	localparam int NW        = 31 + lav_pkg::ROT_FRAC + 1;

	// Shift all three lanes left by s when the top s bits are clear in all
	function automatic logic [2:0][63:0] lz_step(input logic [2:0][63:0] v,
		input int unsigned s);
		logic [63:0]      o;
		logic [2:0][63:0] r;
		o = v[0] | v[1] | v[2];
		r = v;
		if ((o >> (64 - s)) == 64'd0) begin
			for (int i = 0; i < 3; i++) r[i] = v[i] << s;
		end
		return r;
	endfunction

	logic [LAT:1]     vld_q;
	logic [TW-1:0]    tag_q [1:LAT];
	logic [2:0][63:0] mag_c;
	logic [2:0]       sgn_c;
	logic             zero_c;
	logic [2:0][63:0] mag_s1, sh_s2, sh_s3, sh_s4;
	logic [2:0][61:0] sq_s5;
	logic [2:0][30:0] a_s5;

	logic [33:0]      rt_rem  [0:SQ_STEPS];
	logic [31:0]      rt_root [0:SQ_STEPS];
	logic [63:0]      rt_n    [0:SQ_STEPS];
	logic [2:0][30:0] rt_a    [0:SQ_STEPS];

	logic [2:0][31:0] dv_rem [0:DIV_STEPS];
	logic [2:0][14:0] dv_low [0:DIV_STEPS];
	logic [2:0][14:0] dv_q   [0:DIV_STEPS];
	logic [31:0]      dv_l   [0:DIV_STEPS];
	logic [2:0][NW-1:0] num_c;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-1:1], vld_in};
		end
	end

	// Magnitudes, signs and zero flag of the incoming vector
	always_comb begin
		logic [63:0] ext;
		for (int i = 0; i < 3; i++) begin
			ext      = 64'($signed(v_in[i]));
			mag_c[i] = ext[63] ? (64'd0 - ext) : ext;
			sgn_c[i] = v_in[i][W-1];
		end
		zero_c = (v_in == '0);
	end

	// Carry side payload, signs and zero flag down the pipe
	always_ff @(posedge clk) begin
		if (en) begin
			tag_q[1] <= {side_in, sgn_c, zero_c};
			for (int k = 2; k <= LAT; k++) tag_q[k] <= tag_q[k-1];
		end
	end

	// Scale so the largest lane has its top bit at bit 63, two steps a stage
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_c;
			sh_s2  <= lz_step(lz_step(mag_s1, 32), 16);
			sh_s3  <= lz_step(lz_step(sh_s2, 8), 4);
			sh_s4  <= lz_step(lz_step(sh_s3, 2), 1);
		end
	end

	// Keep 31 bits (largest lane in [2^30, 2^31)), square, then sum
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s5[i]  <= sh_s4[i][63:33];
				sq_s5[i] <= 62'(sh_s4[i][63:33]) * 62'(sh_s4[i][63:33]);
			end
			rt_n[0]    <= 64'(sq_s5[0]) + 64'(sq_s5[1]) + 64'(sq_s5[2]);
			rt_rem[0]  <= '0;
			rt_root[0] <= '0;
			rt_a[0]    <= a_s5;
		end
	end

	// Integer square root, one result bit per stage
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		logic [35:0] rem_t;
		logic [35:0] trial;
		logic        take;
		assign rem_t = {rt_rem[k], rt_n[k][63:62]};
		assign trial = {2'b00, rt_root[k], 2'b01};
		assign take  = (rem_t >= trial);
		always_ff @(posedge clk) begin
			if (en) begin
				rt_rem[k+1]  <= take ? 34'(rem_t - trial) : rem_t[33:0];
				rt_root[k+1] <= {rt_root[k][30:0], take};
				rt_n[k+1]    <= {rt_n[k][61:0], 2'b00};
				rt_a[k+1]    <= rt_a[k];
			end
		end
	end

	// Dividend with half the length added for rounding
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_c[i] = {rt_a[SQ_STEPS][i], {lav_pkg::ROT_FRAC{1'b0}}}
				+ NW'(rt_root[SQ_STEPS] >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem[0][i] <= 32'(num_c[i][NW-1:DIV_STEPS]);
				dv_low[0][i] <= num_c[i][DIV_STEPS-1:0];
				dv_q[0][i]   <= '0;
			end
			dv_l[0] <= rt_root[SQ_STEPS];
		end
	end

	// Restoring divide by the length, one quotient bit per stage
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [2:0][32:0] rem_t;
		logic [2:0]       take;
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rem_t[i] = {dv_rem[k][i], dv_low[k][i][14]};
				take[i]  = (rem_t[i] >= {1'b0, dv_l[k]});
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					dv_rem[k+1][i] <= take[i] ? 32'(rem_t[i] - {1'b0, dv_l[k]})
						: rem_t[i][31:0];
					dv_low[k+1][i] <= {dv_low[k][i][13:0], 1'b0};
					dv_q[k+1][i]   <= {dv_q[k][i][13:0], take[i]};
				end
				dv_l[k+1] <= dv_l[k];
			end
		end
	end

	// Apply sign; a zero vector stays zero
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (tag_q[LAT-1][0]) begin
					q_out[i] <= '0;
				end else if (tag_q[LAT-1][i+1]) begin
					q_out[i] <= 16'd0 - {1'b0, dv_q[DIV_STEPS][i]};
				end else begin
					q_out[i] <= {1'b0, dv_q[DIV_STEPS][i]};
				end
			end
		end
	end

	assign vld_out  = vld_q[LAT];
	assign side_out = tag_q[LAT][TW-1:4];

endmodule

`default_nettype wire

>>> rtl/core/look_at_view_matrix.sv
// Look-at view matrix top level: difference, three normalizers, cross
// products, translation and output buffer. Depends on lav_pkg, lav_cmd_if,
// lav_rsp_if and lav_norm3.
//
// Takes one request per clock while the output buffer has room and returns the
// camera rotation rows (side, true up, forward) in Q2.14 and the saturated
// translation -R*eye in the input format, one result per request, in order.
// The path runs through the two normalizers in series, each a 55-stage chain
// of scaling, a 32-stage square root and a 15-stage divider. Two result buffers
// sit in front of res; requests are taken whenever that buffer is not full.
`default_nettype none

module look_at_view_matrix (
	input  wire      clk,
	input  wire      arst_n,
	lav_cmd_if.sink  cmd,
	lav_rsp_if.source res
);

	localparam int NORM_SIDE1 = 192;

	logic en;

	logic             v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [2:0][32:0] d_s1;
	logic [2:0][31:0] eye_s1, up_s1;

	logic             v_n1;
	logic [2:0][15:0] f_n1;
	logic [NORM_SIDE1-1:0] side_n1;
	logic [2:0][31:0] eye_n1, up_n1;

	logic [5:0][47:0] p_s2;
	logic [2:0][15:0] f_s2, f_s3, f_s4, f_s5;
	logic [2:0][31:0] eye_s2, eye_s3, eye_s4, eye_s5;
	logic [2:0][48:0] xs_s3, xs_s4, xs_s5;
	logic [5:0][63:0] p_s4;
	logic [2:0][63:0] yu_s5;

	logic             v_n2, v_n3;
	logic [2:0][15:0] s_n2, u_n3, f_n3;
	logic [2:0][31:0] eye_n2;

	logic                  v_t1, v_t2, v_t3, v_t4;
	logic [2:0][2:0][15:0] rot_t1, rot_t2, rot_t3;
	logic [2:0][2:0][47:0] m_t1;
	logic [2:0][49:0]      dot_t2;
	logic [2:0][36:0]      r_t3;
	logic [2:0]            neg_t3;
	lav_pkg::rsp_t         out_t4;

	logic [1:0]    cnt_q;
	logic          wr_q, rd_q;
	lav_pkg::rsp_t ent_q [2];
	logic          push, pop;

	// Whole pipe advances while the output buffer has room
	assign en        = (cnt_q != 2'd2);
	assign cmd.ready = en;

	// Stage 1: eye minus target
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= 33'($signed(cmd.payload.eye_px)) - 33'($signed(cmd.payload.target_px));
			d_s1[1] <= 33'($signed(cmd.payload.eye_py)) - 33'($signed(cmd.payload.target_py));
			d_s1[2] <= 33'($signed(cmd.payload.eye_pz)) - 33'($signed(cmd.payload.target_pz));
			eye_s1  <= {cmd.payload.eye_pz, cmd.payload.eye_py, cmd.payload.eye_px};
			up_s1   <= {cmd.payload.up_hint_z, cmd.payload.up_hint_y, cmd.payload.up_hint_x};
		end
	end

	// Forward axis
	lav_norm3 #(.W(33), .SW(NORM_SIDE1)) u_norm_fwd (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (v_s1),
		.v_in     (d_s1),
		.side_in  ({eye_s1, up_s1}),
		.vld_out  (v_n1),
		.q_out    (f_n1),
		.side_out (side_n1)
	);

	assign eye_n1 = side_n1[NORM_SIDE1-1:96];
	assign up_n1  = side_n1[95:0];

	// Stages 2-5: side = up x f, true up = f x side (unnormalized)
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= 48'($signed(up_n1[1]) * $signed(f_n1[2]));
			p_s2[1] <= 48'($signed(up_n1[2]) * $signed(f_n1[1]));
			p_s2[2] <= 48'($signed(up_n1[2]) * $signed(f_n1[0]));
			p_s2[3] <= 48'($signed(up_n1[0]) * $signed(f_n1[2]));
			p_s2[4] <= 48'($signed(up_n1[0]) * $signed(f_n1[1]));
			p_s2[5] <= 48'($signed(up_n1[1]) * $signed(f_n1[0]));
			f_s2    <= f_n1;
			eye_s2  <= eye_n1;

			for (int i = 0; i < 3; i++) begin
				xs_s3[i] <= 49'($signed(p_s2[2*i])) - 49'($signed(p_s2[2*i+1]));
			end
			f_s3   <= f_s2;
			eye_s3 <= eye_s2;

			p_s4[0] <= 64'($signed(f_s3[1]) * $signed(xs_s3[2]));
			p_s4[1] <= 64'($signed(f_s3[2]) * $signed(xs_s3[1]));
			p_s4[2] <= 64'($signed(f_s3[2]) * $signed(xs_s3[0]));
			p_s4[3] <= 64'($signed(f_s3[0]) * $signed(xs_s3[2]));
			p_s4[4] <= 64'($signed(f_s3[0]) * $signed(xs_s3[1]));
			p_s4[5] <= 64'($signed(f_s3[1]) * $signed(xs_s3[0]));
			xs_s4   <= xs_s3;
			f_s4    <= f_s3;
			eye_s4  <= eye_s3;

			for (int i = 0; i < 3; i++) begin
				yu_s5[i] <= p_s4[2*i] - p_s4[2*i+1];
			end
			xs_s5  <= xs_s4;
			f_s5   <= f_s4;
			eye_s5 <= eye_s4;
		end
	end

	// Side and true up axes, in parallel with equal latency
	lav_norm3 #(.W(49), .SW(96)) u_norm_side (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (v_s5),
		.v_in     (xs_s5),
		.side_in  (eye_s5),
		.vld_out  (v_n2),
		.q_out    (s_n2),
		.side_out (eye_n2)
	);

	lav_norm3 #(.W(64), .SW(48)) u_norm_up (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (v_s5),
		.v_in     (yu_s5),
		.side_in  (f_s5),
		.vld_out  (v_n3),
		.q_out    (u_n3),
		.side_out (f_n3)
	);

	// Translation: products, dot, round half away from zero, saturate
	always_ff @(posedge clk) begin
		if (en) begin
			rot_t1 <= {f_n3, u_n3, s_n2};
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					m_t1[r][c] <= 48'($signed(eye_n2[c])
						* $signed(r == 0 ? s_n2[c] : (r == 1 ? u_n3[c] : f_n3[c])));
				end
			end

			rot_t2 <= rot_t1;
			for (int r = 0; r < 3; r++) begin
				dot_t2[r] <= 50'($signed(m_t1[r][0])) + 50'($signed(m_t1[r][1]))
					+ 50'($signed(m_t1[r][2]));
			end

			rot_t3 <= rot_t2;
			for (int r = 0; r < 3; r++) begin
				logic [50:0] nn;
				logic [50:0] mg;
				nn = 51'd0 - 51'($signed(dot_t2[r]));
				mg = nn[50] ? (51'd0 - nn) : nn;
				neg_t3[r] <= nn[50];
				r_t3[r]   <= 37'((mg + (51'd1 << (lav_pkg::ROT_FRAC - 1)))
					>> lav_pkg::ROT_FRAC);
			end

			out_t4.side_ax   <= rot_t3[0][0];
			out_t4.side_ay   <= rot_t3[0][1];
			out_t4.side_az   <= rot_t3[0][2];
			out_t4.true_up_x <= rot_t3[1][0];
			out_t4.true_up_y <= rot_t3[1][1];
			out_t4.true_up_z <= rot_t3[1][2];
			out_t4.fwd_ax    <= rot_t3[2][0];
			out_t4.fwd_ay    <= rot_t3[2][1];
			out_t4.fwd_az    <= rot_t3[2][2];
			out_t4.shift_x   <= sat32(neg_t3[0], r_t3[0]);
			out_t4.shift_y   <= sat32(neg_t3[1], r_t3[1]);
			out_t4.shift_z   <= sat32(neg_t3[2], r_t3[2]);
		end
	end

	function automatic logic [31:0] sat32(input logic neg, input logic [36:0] r);
		logic [31:0] o;
		if (neg) begin
			o = (r > 37'h0_8000_0000) ? 32'h8000_0000 : 32'(37'd0 - r);
		end else begin
			o = (r > 37'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
		end
		return o;
	endfunction

	// Valid bits of the top-level stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5} <= '0;
			{v_t1, v_t2, v_t3, v_t4}       <= '0;
		end else if (en) begin
			v_s1 <= cmd.valid;
			v_s2 <= v_n1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_t1 <= v_n2;
			v_t2 <= v_t1;
			v_t3 <= v_t2;
			v_t4 <= v_t3;
		end
	end

	// Two-entry output buffer: push from the pipe, pop on res transfer
	assign push = en && v_t4;
	assign pop  = res.valid && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= out_t4;
	end

	assign res.valid   = (cnt_q != 2'd0);
	assign res.payload = ent_q[rd_q];

	// Checks
	logic fwd_zero;
	logic rot_ok;
	assign fwd_zero = (res.payload.fwd_ax == 16'sd0) && (res.payload.fwd_ay == 16'sd0)
		&& (res.payload.fwd_az == 16'sd0);
	assign rot_ok = (res.payload.fwd_ax <= 16'sd16384) && (res.payload.fwd_ax >= -16'sd16384)
		&& (res.payload.side_ax <= 16'sd16384) && (res.payload.side_ax >= -16'sd16384)
		&& (res.payload.true_up_z <= 16'sd16384) && (res.payload.true_up_z >= -16'sd16384);

	a_norm_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		v_n2 == v_n3)
		else $error("side and up normalizers out of step");

	a_buf_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer overrun");

	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> rot_ok)
		else $error("rotation entry beyond unit range");

	a_zero_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && fwd_zero) |-> (res.payload.shift_z == 32'sd0
			&& res.payload.side_ax == 16'sd0 && res.payload.true_up_y == 16'sd0))
		else $error("zero forward axis with nonzero side, up or shift");

endmodule

`default_nettype wire
